### sv/csoe_pkg.sv
// ----------------------------------------------------------------------------
// csoe_pkg
// Shared constants, codes and arithmetic helpers for the offset-calibrated
// current sense filter.
// ----------------------------------------------------------------------------
package csoe_pkg;

  // adc and window sizing
  localparam int ADC_BITS   = 12;
  localparam int MAX_WINDOW = 1024;
  localparam int FRAC_BITS  = 8;
  localparam int CNT_W      = $clog2(MAX_WINDOW) + 1;
  localparam int SUM_W      = ADC_BITS + CNT_W - 1;
  localparam int DVD_W      = SUM_W + FRAC_BITS;
  localparam int AVG_W      = ADC_BITS + FRAC_BITS;
  localparam int STEP_W     = $clog2(DVD_W);

  // register widths
  localparam int SPR_W    = 11;
  localparam int MARGIN_W = 12;
  localparam int GAIN_W   = 24;
  localparam int ALPHA_W  = 16;
  localparam int DB_W     = 31;
  localparam int CFG_W    = 31;
  localparam int IDX_W    = 3;

  // register reset values
  localparam logic [SPR_W-1:0]    SPR_RST    = 11'd16;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 12'd82;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 24'd1048576;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd3277;
  localparam logic [DB_W-1:0]     DB_RST     = 31'd0;

  // alpha of one in q1.15
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'd32768;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SPR    = 3'd0;
  localparam logic [IDX_W-1:0] REG_MARGIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ALPHA  = 3'd3;
  localparam logic [IDX_W-1:0] REG_DB     = 3'd4;

  // action codes
  localparam logic [1:0] ACT_MEASURE = 2'd0;
  localparam logic [1:0] ACT_CALIB   = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // status codes
  localparam logic [1:0] ST_READING   = 2'd0;
  localparam logic [1:0] ST_CAL_OK    = 2'd1;
  localparam logic [1:0] ST_CAL_BAD   = 2'd2;
  localparam logic [1:0] ST_NOT_CAL   = 2'd3;

  // product width of the shared multiplier
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // divide by 2^sh rounding half away from zero, saturate to 32 bits signed
  function automatic logic signed [31:0] rnd_sat32(input logic signed [PROD_W-1:0] v,
                                                   input int unsigned sh);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    logic [31:0]       res;
    mag = v[PROD_W-1] ? $unsigned(-v) : $unsigned(v);
    q   = (mag + ({{(PROD_W-1){1'b0}}, 1'b1} << (sh - 1))) >> sh;
    if (v[PROD_W-1]) begin
      res = (q >= PROD_W'(64'h8000_0000)) ? 32'h8000_0000 : 32'(PROD_W'(0) - q);
    end else begin
      res = (q > PROD_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end
    return $signed(res);
  endfunction

  // zero a value whose magnitude lies below the deadband
  function automatic logic signed [31:0] apply_deadband(input logic signed [31:0] v,
                                                        input logic [DB_W-1:0] db);
    logic [31:0] mag;
    mag = v[31] ? 32'(33'd0 - {v[31], v}) : $unsigned(v);
    return (mag < {1'b0, db}) ? 32'sd0 : v;
  endfunction

endpackage

### sv/csoe_div.sv
// ----------------------------------------------------------------------------
// csoe_div
// Restoring divider, one quotient bit per cycle, for the window average.
// ----------------------------------------------------------------------------
module csoe_div
  import csoe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [AVG_W-1:0] quotient
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dsr_r;
  logic [DVD_W-1:0]  q_r;

  logic [CNT_W:0]    shifted;
  logic [CNT_W+1:0]  diff;

  // trial subtract of the divisor from the shifted remainder
  assign shifted = {rem_r, q_r[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dsr_r <= divisor;
      q_r   <= dividend;
    end else if (busy_r) begin
      if (!diff[CNT_W+1]) begin
        rem_r <= diff[CNT_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[CNT_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r[AVG_W-1:0];

endmodule

### sv/current_sense_offset_ema_top.sv
// ----------------------------------------------------------------------------
// current_sense_offset_ema_top
// Offset-calibrated current sensor: window average, offset check, gain and
// exponential moving average with deadband on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one adc sample per beat, tagged with an action (measure,
//           calibrate, clear filter). in_ready is high only while idle.
//   out_* : one result beat per finished window, per measure while not
//           calibrated; held in an output register until out_ready.
//   cfg_* : register writes, taken at once; user must write only while idle (not enforced).
// Timing
//   a sample that does not finish a window, or a clear, is taken and the
//   block is ready again on the next cycle. a measure while uncalibrated
//   goes straight to the output state and then into the output register.
//   a finished calibration window runs the 30-step bit-serial divider and
//   the offset check; a finished measure window adds three multiplier passes.
// Reset and stall
//   rst_n (synchronous) restores register defaults, clears window, offset,
//   filter and calibrated flag. while out_ready is low a finished result
//   waits in the output register; the block keeps taking samples that give
//   no result and only stalls when a second result is ready.
// ----------------------------------------------------------------------------
module current_sense_offset_ema_top
  import csoe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [ADC_BITS-1:0] in_adc_sample,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_current_out,
  output logic [1:0]          out_status,
  output logic                out_is_calibrated,
  output logic [AVG_W-1:0]    out_offset_code,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIV  = 11'b000_0000_0010,
    S_CHK  = 11'b000_0000_0100,
    S_MUL1 = 11'b000_0000_1000,
    S_RND1 = 11'b000_0001_0000,
    S_MUL2 = 11'b000_0010_0000,
    S_MUL3 = 11'b000_0100_0000,
    S_ACC  = 11'b000_1000_0000,
    S_RND2 = 11'b001_0000_0000,
    S_DB   = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state_r;

  // configuration registers
  logic [SPR_W-1:0]    spr_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [ALPHA_W-1:0]  alpha_r;
  logic [DB_W-1:0]     db_r;

  // filter state
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                mode_r;
  logic [AVG_W-1:0]    offset_r;
  logic signed [31:0]  filt_r;
  logic                calib_r;

  // working registers
  logic signed [AVG_W:0]    delta_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [31:0]       raw_r;
  logic signed [31:0]       res_cur_r;
  logic [1:0]               res_status_r;

  // output register
  logic                out_valid_r;
  logic signed [31:0]  out_cur_r;
  logic [1:0]          out_status_r;
  logic                out_cal_r;
  logic [AVG_W-1:0]    out_offset_r;

  logic                in_fire;
  logic                mode_bit;
  logic [SUM_W-1:0]    sum_nxt;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [CNT_W-1:0]    n_eff;
  logic                win_done;
  logic                div_start;
  logic                div_done;
  logic [AVG_W-1:0]    avg;
  logic [ALPHA_W-1:0]  alpha_c;
  logic [ALPHA_W-1:0]  alpha_inv;
  logic [AVG_W-1:0]    cal_lo;
  logic [AVG_W-1:0]    cal_hi;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // window size clamp and alpha clamp
  always_comb begin
    if (spr_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (spr_r > SPR_W'(MAX_WINDOW)) begin
      n_eff = CNT_W'(MAX_WINDOW);
    end else begin
      n_eff = CNT_W'(spr_r);
    end
    alpha_c   = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    alpha_inv = ALPHA_ONE - alpha_c;
  end

  // window accumulate, restarting on a mode change
  assign mode_bit = (in_action == ACT_CALIB);
  always_comb begin
    if (mode_r != mode_bit) begin
      sum_nxt = SUM_W'(in_adc_sample);
      cnt_nxt = CNT_W'(1);
    end else begin
      sum_nxt = sum_r + SUM_W'(in_adc_sample);
      cnt_nxt = cnt_r + 1'b1;
    end
  end
  assign win_done  = (cnt_nxt >= n_eff);
  assign div_start = in_fire && win_done &&
                     ((in_action == ACT_CALIB) || (in_action == ACT_MEASURE && calib_r));

  // window average: (sum * 256) / count
  csoe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_nxt, FRAC_BITS'(0)}),
    .divisor  (cnt_nxt),
    .done     (div_done),
    .quotient (avg)
  );

  // calibration window limits, margin codes from each rail
  assign cal_lo = {margin_r, FRAC_BITS'(0)};
  assign cal_hi = {MARGIN_W'((1 << ADC_BITS) - 1) - margin_r, FRAC_BITS'(0)};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL1: begin
        mul_a = MUL_A_W'(delta_r);
        mul_b = $signed({1'b0, gain_r});
      end
      S_MUL2: begin
        mul_a = MUL_A_W'(raw_r);
        mul_b = $signed(MUL_B_W'(alpha_c));
      end
      S_MUL3: begin
        mul_a = MUL_A_W'(filt_r);
        mul_b = $signed(MUL_B_W'(alpha_inv));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r    <= SPR_RST;
      margin_r <= MARGIN_RST;
      gain_r   <= GAIN_RST;
      alpha_r  <= ALPHA_RST;
      db_r     <= DB_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SPR:    spr_r    <= cfg_wdata[SPR_W-1:0];
        REG_MARGIN: margin_r <= cfg_wdata[MARGIN_W-1:0];
        REG_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
        REG_ALPHA:  alpha_r  <= cfg_wdata[ALPHA_W-1:0];
        REG_DB:     db_r     <= cfg_wdata[DB_W-1:0];
        default:    ;
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sum_r    <= '0;
      cnt_r    <= '0;
      mode_r   <= 1'b0;
      offset_r <= '0;
      filt_r   <= '0;
      calib_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_action) inside
              ACT_CLEAR: filt_r <= '0;
              ACT_MEASURE, ACT_CALIB: begin
                if (in_action == ACT_MEASURE && !calib_r) begin
                  state_r <= S_OUT;
                end else begin
                  mode_r <= mode_bit;
                  if (win_done) begin
                    sum_r   <= '0;
                    cnt_r   <= '0;
                    state_r <= S_DIV;
                  end else begin
                    sum_r <= sum_nxt;
                    cnt_r <= cnt_nxt;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (mode_r) begin
            if (avg >= cal_lo && avg <= cal_hi) begin
              offset_r <= avg;
              filt_r   <= '0;
              calib_r  <= 1'b1;
            end
            state_r <= S_OUT;
          end else begin
            state_r <= S_MUL1;
          end
        end
        S_MUL1: state_r <= S_RND1;
        S_RND1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_MUL3;
        S_MUL3: state_r <= S_ACC;
        S_ACC:  state_r <= S_RND2;
        S_RND2: begin
          filt_r  <= rnd_sat32(acc_r, 15);
          state_r <= S_DB;
        end
        S_DB:   state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        res_cur_r    <= '0;
        res_status_r <= ST_NOT_CAL;
      end
      S_CHK: begin
        delta_r <= $signed({1'b0, avg}) - $signed({1'b0, offset_r});
        if (avg >= cal_lo && avg <= cal_hi) begin
          res_cur_r    <= '0;
          res_status_r <= ST_CAL_OK;
        end else begin
          res_cur_r    <= apply_deadband(filt_r, db_r);
          res_status_r <= ST_CAL_BAD;
        end
      end
      S_MUL1: prod_r <= mul_p;
      S_RND1: raw_r  <= rnd_sat32(prod_r, 12);
      S_MUL2: acc_r  <= mul_p;
      S_MUL3: prod_r <= mul_p;
      S_ACC:  acc_r  <= acc_r + prod_r;
      S_DB: begin
        res_cur_r    <= apply_deadband(filt_r, db_r);
        res_status_r <= ST_READING;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_cur_r    <= res_cur_r;
      out_status_r <= res_status_r;
      out_cal_r    <= calib_r;
      out_offset_r <= offset_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_out   = out_cur_r;
  assign out_status        = out_status_r;
  assign out_is_calibrated = out_cal_r;
  assign out_offset_code   = out_offset_r;

  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider done outside divide state");

  // calibration, once accepted, is never lost
  a_calib_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(calib_r))
    else $error("calibrated flag dropped");

  // not-calibrated result carries a clear flag and zero current
  a_notcal_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_NOT_CAL) |-> (!out_cal_r && out_cur_r == '0))
    else $error("not-calibrated beat inconsistent");

  // accepted calibration reports zero current and a set flag
  a_calok_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_CAL_OK) |-> (out_cal_r && out_cur_r == '0))
    else $error("calibration accepted beat inconsistent");

endmodule

### dv/current_sense_offset_ema_top_tb.sv
// ----------------------------------------------------------------------------
// current_sense_offset_ema_top_tb
// Self-checking bench for the offset-calibrated current sense filter. Samples
// are pushed through the input channel with random gaps, and a shadow
// predictor that mirrors the window, offset, gain, ema and deadband math works
// out the result beat, if any, for each accepted sample. The result channel is
// stalled at random and once for a long stretch; every result beat is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module current_sense_offset_ema_top_tb;
  import csoe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                  SETTLE_CYCLES = 60;
  localparam int                  RANDOM_BEATS  = 480;
  localparam int                  PHASE_BEATS   = 50;
  localparam int unsigned         LIMIT_CYCLES  = 1000000;
  localparam logic [ADC_BITS-1:0] CODE_MAX      = '1;

  typedef struct packed {
    logic signed [31:0] current;
    logic [1:0]         status;
    logic               cal;
    logic [AVG_W-1:0]   offset;
  } sense_result_t;

  // dut ports
  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_action = ACT_MEASURE;
  logic [ADC_BITS-1:0] in_adc_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [31:0]  out_current_out;
  logic [1:0]          out_status;
  logic                out_is_calibrated;
  logic [AVG_W-1:0]    out_offset_code;
  logic                cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]    cfg_index = REG_SPR;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  // shadow registers
  logic [SPR_W-1:0]    m_spr    = SPR_RST;
  logic [MARGIN_W-1:0] m_margin = MARGIN_RST;
  logic [GAIN_W-1:0]   m_gain   = GAIN_RST;
  logic [ALPHA_W-1:0]  m_alpha  = ALPHA_RST;
  logic [DB_W-1:0]     m_db     = DB_RST;

  // shadow sensor state
  longint unsigned     m_sum    = 0;
  longint unsigned     m_count  = 0;
  logic                m_mode   = 1'b0;
  logic [AVG_W-1:0]    m_offset = '0;
  logic signed [31:0]  m_filt   = '0;
  logic                m_cal    = 1'b0;

  sense_result_t pending_results[$];

  // bench bookkeeping
  bit          steady = 1'b0;
  int          ready_hold = 0;
  int unsigned useful_beats = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  current_sense_offset_ema_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_adc_sample    (in_adc_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_current_out  (out_current_out),
    .out_status       (out_status),
    .out_is_calibrated(out_is_calibrated),
    .out_offset_code  (out_offset_code),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // divide by 2^sh, ties away from zero
  function automatic longint shift_round_half_away(input longint v, input int sh);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [31:0] clamp_to_s32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // zero the reading when its magnitude sits under the deadband
  function automatic logic signed [31:0] gate_deadband(input logic signed [31:0] v);
    longint mag;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    return (mag < longint'(m_db)) ? 32'sd0 : v;
  endfunction

  // advance the shadow sensor by one sample, return 1 when a result is due
  function automatic bit predict_sense_step(input logic [1:0] act,
                                            input logic [ADC_BITS-1:0] code,
                                            output sense_result_t r);
    logic            want_cal;
    longint unsigned n;
    longint          avg, lo, hi, delta, raw, a, acc;
    r = '0;
    if (act == ACT_NONE) return 1'b0;
    if (act == ACT_CLEAR) begin
      m_filt = '0;
      return 1'b0;
    end
    // measure before any calibration answers at once
    if (act == ACT_MEASURE && !m_cal) begin
      r.current = '0;
      r.status  = ST_NOT_CAL;
      r.cal     = m_cal;
      r.offset  = m_offset;
      return 1'b1;
    end
    // switching between calibrate and measure drops the partial window
    want_cal = (act == ACT_CALIB);
    if (m_mode != want_cal) begin
      m_mode  = want_cal;
      m_sum   = 0;
      m_count = 0;
    end
    m_sum   += 64'(code);
    m_count += 1;
    n = 64'(m_spr);
    if (n == 0) n = 1;
    if (n > MAX_WINDOW) n = MAX_WINDOW;
    if (m_count < n) return 1'b0;
    avg     = longint'((m_sum << FRAC_BITS) / m_count);
    m_sum   = 0;
    m_count = 0;
    if (want_cal) begin
      lo = longint'(m_margin) << FRAC_BITS;
      hi = (longint'(CODE_MAX) - longint'(m_margin)) * 256;
      if (avg < lo || avg > hi) begin
        r.current = gate_deadband(m_filt);
        r.status  = ST_CAL_BAD;
      end else begin
        m_offset  = avg[AVG_W-1:0];
        m_filt    = '0;
        m_cal     = 1'b1;
        r.current = '0;
        r.status  = ST_CAL_OK;
      end
    end else begin
      delta     = avg - longint'(m_offset);
      raw       = clamp_to_s32(shift_round_half_away(delta * longint'(m_gain), 12));
      a         = (m_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(m_alpha);
      acc       = a * raw + (longint'(ALPHA_ONE) - a) * longint'(m_filt);
      m_filt    = clamp_to_s32(shift_round_half_away(acc, 15));
      r.current = gate_deadband(m_filt);
      r.status  = ST_READING;
    end
    r.cal    = m_cal;
    r.offset = m_offset;
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input sense_result_t want,
                                 input sense_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: want cur=%0d st=%0d cal=%0d off=%0h | got cur=%0d st=%0d cal=%0d off=%0h",
               $realtime, what, want.current, want.status, want.cal, want.offset,
               got.current, got.status, got.cal, got.offset);
  endtask

  always @(posedge clk) begin : check_beat
    sense_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.current = out_current_out;
      got.status  = out_status;
      got.cal     = out_is_calibrated;
      got.offset  = out_offset_code;
      results_checked++;
      status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) report_mismatch("result beat differs", want, got);
      end
    end
  end

  // result side: random stalls, a held-off stretch on request, or always ready
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold = ready_hold - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 35);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------

  // offer one sample beat, wait for it to be taken, then predict
  task automatic send_beat(input logic [1:0] act, input logic [ADC_BITS-1:0] code);
    sense_result_t r;
    int gap;
    gap = 0;
    if (!steady)
      while ($urandom_range(0, 99) < 35) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_adc_sample <= code;
    do @(posedge clk); while (!in_ready);
    if (predict_sense_step(act, code, r)) pending_results.push_back(r);
    if (act != ACT_NONE) useful_beats++;
  endtask

  // drop valid and let the block drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value);
    settle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_SPR:    m_spr    = value[SPR_W-1:0];
      REG_MARGIN: m_margin = value[MARGIN_W-1:0];
      REG_GAIN:   m_gain   = value[GAIN_W-1:0];
      REG_ALPHA:  m_alpha  = value[ALPHA_W-1:0];
      REG_DB:     m_db     = value[DB_W-1:0];
      default: ;
    endcase
  endtask

  function automatic int window_len();
    if (m_spr == 0) return 1;
    if (m_spr > MAX_WINDOW) return MAX_WINDOW;
    return int'(m_spr);
  endfunction

  function automatic logic [ADC_BITS-1:0] any_code();
    return ADC_BITS'($urandom_range(0, CODE_MAX));
  endfunction

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // status codes, window handling and mode switching at default margin, gain, alpha and deadband
  task automatic test_directed_cases();
    write_reg(REG_SPR, 1);
    // uncalibrated measures, ignored action, filter clear
    send_beat(ACT_MEASURE, '0);
    send_beat(ACT_MEASURE, CODE_MAX);
    send_beat(ACT_NONE, CODE_MAX);
    send_beat(ACT_CLEAR, CODE_MAX);
    // rejected at both rails, then accepted at midscale
    send_beat(ACT_CALIB, '0);
    send_beat(ACT_CALIB, CODE_MAX);
    send_beat(ACT_CALIB, 12'd2048);
    send_beat(ACT_MEASURE, CODE_MAX);
    send_beat(ACT_MEASURE, '0);
    send_beat(ACT_CLEAR, '0);
    send_beat(ACT_MEASURE, 12'd2100);
    // partial calibration window dropped by a measure
    write_reg(REG_SPR, 3);
    send_beat(ACT_CALIB, 12'd2000);
    send_beat(ACT_CALIB, 12'd2001);
    send_beat(ACT_MEASURE, 12'd3000);
    send_beat(ACT_MEASURE, 12'd100);
    send_beat(ACT_MEASURE, CODE_MAX);
    // window shortened while partly filled completes on the next sample
    write_reg(REG_SPR, 4);
    send_beat(ACT_MEASURE, 12'd1000);
    send_beat(ACT_MEASURE, 12'd1500);
    write_reg(REG_SPR, 1);
    send_beat(ACT_MEASURE, 12'd2500);
    // rejected calibration reports the live filter value
    send_beat(ACT_CALIB, CODE_MAX);
  endtask

  // register extremes: margins, gain and alpha saturation, deadband, window size
  task automatic test_register_extremes();
    write_reg(REG_SPR, 1);
    // margins past half the range reject everything
    write_reg(REG_MARGIN, 4095);
    send_beat(ACT_CALIB, 12'd2048);
    write_reg(REG_MARGIN, 2048);
    send_beat(ACT_CALIB, 12'd2048);
    // zero margin accepts a rail as offset
    write_reg(REG_MARGIN, 0);
    send_beat(ACT_CALIB, '0);
    write_reg(REG_GAIN, 32'h00FF_FFFF);
    write_reg(REG_ALPHA, 32'(ALPHA_ONE));
    send_beat(ACT_MEASURE, CODE_MAX);
    write_reg(REG_ALPHA, 32'h0000_FFFF);
    send_beat(ACT_MEASURE, '0);
    send_beat(ACT_MEASURE, CODE_MAX);
    // top rail offset drives negative saturation
    send_beat(ACT_CALIB, CODE_MAX);
    send_beat(ACT_MEASURE, '0);
    write_reg(REG_DB, 32'h7FFF_FFFF);
    send_beat(ACT_MEASURE, '0);
    send_beat(ACT_MEASURE, 12'd4094);
    // zero alpha holds the filter, zero gain gives zero readings
    write_reg(REG_ALPHA, 0);
    send_beat(ACT_MEASURE, 12'd2048);
    write_reg(REG_DB, 65536);
    send_beat(ACT_MEASURE, 12'd2048);
    write_reg(REG_GAIN, 0);
    send_beat(ACT_CLEAR, '0);
    write_reg(REG_ALPHA, 32'(ALPHA_RST));
    send_beat(ACT_MEASURE, '0);
    // zero window size behaves as one
    write_reg(REG_GAIN, 32'(GAIN_RST));
    write_reg(REG_MARGIN, 32'(MARGIN_RST));
    write_reg(REG_DB, 32'(DB_RST));
    write_reg(REG_SPR, 0);
    send_beat(ACT_CALIB, 12'd2048);
    repeat (3) send_beat(ACT_MEASURE, any_code());
    // oversized window size ends no short window; lowering it ends it next
    write_reg(REG_SPR, 32'h7FF);
    repeat (5) send_beat(ACT_CALIB, ADC_BITS'($urandom_range(1500, 2600)));
    write_reg(REG_SPR, 1);
    send_beat(ACT_CALIB, ADC_BITS'($urandom_range(1500, 2600)));
    send_beat(ACT_MEASURE, any_code());
  endtask

  // one random well-formed window, or a clear, an ignored beat or noise
  task automatic send_random_sequence();
    int pick, n;
    pick = $urandom_range(0, 99);
    n    = window_len();
    if (pick < 15) begin
      repeat (n)
        send_beat(ACT_CALIB, ($urandom_range(0, 3) == 0) ? any_code()
                               : ADC_BITS'($urandom_range(1200, 2900)));
    end else if (pick < 75) begin
      repeat (n) send_beat(ACT_MEASURE, any_code());
    end else if (pick < 83) begin
      send_beat(ACT_CLEAR, any_code());
    end else if (pick < 88) begin
      send_beat(ACT_NONE, any_code());
    end else begin
      repeat ($urandom_range(1, n)) send_beat(2'($urandom_range(0, 3)), any_code());
    end
  endtask

  task automatic pick_random_registers();
    int r;
    r = $urandom_range(0, 99);
    write_reg(REG_SPR, (r < 70) ? $urandom_range(1, 4) :
                       (r < 90) ? $urandom_range(5, 12) :
                       (r < 96) ? 0 : $urandom_range(13, 40));
    r = $urandom_range(0, 99);
    write_reg(REG_MARGIN, (r < 80) ? $urandom_range(0, 300) : $urandom_range(0, 4095));
    r = $urandom_range(0, 99);
    write_reg(REG_GAIN, (r < 10) ? 0 : (r < 20) ? 32'h00FF_FFFF
                                                : $urandom_range(0, 24'hFF_FFFF));
    r = $urandom_range(0, 99);
    write_reg(REG_ALPHA, (r < 10) ? 0 : (r < 20) ? 32'(ALPHA_ONE) :
                         (r < 25) ? $urandom_range(32769, 65535) : $urandom_range(0, 32768));
    r = $urandom_range(0, 99);
    write_reg(REG_DB, (r < 50) ? 0 : (r < 80) ? $urandom_range(0, 1 << 20)
                                              : ($urandom & 32'h7FFF_FFFF));
  endtask

  // random phases, each with its own register settings
  task automatic test_random_phases();
    int unsigned start, phase_end;
    int phase;
    start = useful_beats;
    phase = 0;
    while (useful_beats - start < RANDOM_BEATS) begin
      pick_random_registers();
      steady = (phase == 2);
      phase_end = useful_beats + PHASE_BEATS;
      while (useful_beats < phase_end) send_random_sequence();
      phase++;
    end
    steady = 1'b0;
  endtask

  // hold the result side off while results keep coming, so the input stalls
  task automatic test_output_backpressure();
    write_reg(REG_SPR, 1);
    write_reg(REG_MARGIN, 32'(MARGIN_RST));
    send_beat(ACT_CALIB, 12'd2048);
    ready_hold = 300;
    repeat (24) send_beat(ACT_MEASURE, any_code());
  endtask

  // ------------------------------------------------------------------------
  // run
  // ------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_register_extremes();
    test_output_backpressure();
    test_random_phases();

    settle();
    $display("covered %0d sample beats and %0d result beats in %0d cycles", useful_beats,
             results_checked, cycle_count);
    $display("readings %0d, calibrations ok %0d / rejected %0d, uncalibrated %0d",
             status_seen[ST_READING], status_seen[ST_CAL_OK], status_seen[ST_CAL_BAD],
             status_seen[ST_NOT_CAL]);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
